[rtl/core/psbq_pkg.sv]
// Package for the panel switch binding qualifier.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package psbq_pkg;
  localparam int unsigned ConfFloorRaw = 307;
  localparam int unsigned ConfFloor = (ConfFloorRaw > 972) ? 972 : ConfFloorRaw;

  typedef enum logic [1:0] {
    MODE_OBSERVE  = 2'd0,
    MODE_RESET_Z  = 2'd1,
    MODE_RESET_NZ = 2'd2,
    MODE_BYPASS   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_LAYER_DZ  = 3'd0,
    REG_JUMP_MIN  = 3'd1,
    REG_JUMP_TOL  = 3'd2,
    REG_YAW_GATE  = 3'd3,
    REG_MARGIN    = 3'd4,
    REG_CONFIRM   = 3'd5,
    REG_COOLDOWN  = 3'd6,
    REG_EMA_ALPHA = 3'd7
  } reg_e;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [27:0] num;
    logic [17:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [27:0] quot;
  } div_rsp_t;
endpackage

[rtl/core/panel_switch_binding_qualifier_unit.sv]
// Panel switch binding qualifier top level: config registers, sequencer,
// binding state and output register. Depends on psbq_pkg and psbq_div.
// Sequence: observe items go through evaluate, two passes on the shared
//   divider, score and finish steps before the result is valid; reset and
//   bypass items go from evaluate straight to finish.
// Throughput: one item at a time; in_stall_o is high until the result leaves,
//   so the next item is accepted in the cycle after that at the earliest.
// Reset: asynchronous active low; config and binding registers return to defaults, unbound.
`timescale 1ns / 1ps
module panel_switch_binding_qualifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  candidate_panel_i,
  input  logic [1:0]  candidate_label_i,
  input  logic [10:0] candidate_conf_i,
  input  logic signed [15:0] obs_z_i,
  input  logic [15:0] cost_margin_i,
  input  logic        cost_margin_valid_i,
  input  logic [15:0] yaw_err_i,
  input  logic        yaw_err_valid_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  bound_panel_o,
  output logic [1:0]  bound_label_o,
  output logic [10:0] selected_conf_o,
  output logic [10:0] binding_conf_o,
  output logic        switch_done_o,
  output logic        in_transition_o
);
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EVAL  = 7'b0000010,
    ST_DIVM  = 7'b0000100,
    ST_DIVY  = 7'b0001000,
    ST_SCORE = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e st_q, st_d;

  // config
  logic [11:0] dz_q, jmin_q, jtol_q, ygate_q;
  logic [15:0] mmin_q;
  logic [3:0]  conf_q;
  logic [7:0]  cool_q;
  logic [10:0] alpha_q;

  // binding state
  logic        bvalid_q, bvalid_d;
  logic [1:0]  bidx_q, bidx_d, blayer_q, blayer_d;
  logic        tflag_q, tflag_d;
  logic [1:0]  tpanel_q, tpanel_d;
  logic [3:0]  tcnt_q, tcnt_d;
  logic [7:0]  cdl_q, cdl_d;
  logic signed [15:0] pz_q, pz_d;
  logic        pzv_q, pzv_d;
  logic [15:0] jest_q, jest_d;
  logic        jestv_q, jestv_d;
  logic [10:0] bconf_q, bconf_d;

  // item registers
  logic [1:0]  mode_q, cand_q, label_q;
  logic [10:0] cconf_q;
  logic signed [15:0] z_q;
  logic [15:0] marg_q, yaw_q;
  logic        yawv_q;
  logic [10:0] ms_q, ms_d, ys_q, ys_d;
  logic        gate_q, gate_d, done_q, done_d;
  logic [16:0] ajump_q, ajump_d;
  logic signed [16:0] jump_q, jump_d;

  // output register
  logic [1:0]  o_panel_q, o_label_q;
  logic [10:0] o_sel_q, o_bconf_q;
  logic        o_done_q, o_trans_q;

  psbq_pkg::div_req_t dreq;
  psbq_pkg::div_rsp_t drsp;

  psbq_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  logic accept;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);

  function automatic logic [1:0] pick_layer(input logic [1:0] lb, input logic [1:0] p);
    if (lb == 2'd1 || lb == 2'd2) return lb;
    return p[0] ? 2'd2 : 2'd1;
  endfunction

  // combinational gate work on the item (narrow compares only)
  logic        eff_bvalid, eff_pzv, eff_jestv;
  logic [1:0]  eff_bidx;
  logic signed [16:0] jraw;
  logic [16:0] ajraw, jdiff;
  logic [1:0]  pdiff;
  logic        adj, mag_ok, match_ok, yaw_ok, marg_ok, g_ok;
  logic [11:0] ygate_eff;
  logic [15:0] mmin_eff;
  logic [3:0]  need;
  logic [7:0]  cdl_dec;
  logic [4:0]  tcnt_inc;

  always_comb begin
    eff_bvalid = bvalid_q;
    eff_pzv    = bvalid_q ? pzv_q : 1'b1;
    eff_jestv  = bvalid_q ? jestv_q : 1'b0;
    eff_bidx   = bvalid_q ? bidx_q : cand_q;
    jraw   = eff_pzv && bvalid_q ? ({z_q[15], z_q} - {pz_q[15], pz_q}) : 17'sd0;
    ajraw  = jraw[16] ? 17'(-jraw) : 17'(jraw);
    pdiff  = cand_q - eff_bidx;
    adj    = (pdiff == 2'd1) || (pdiff == 2'd3);
    mag_ok = eff_pzv && (ajraw >= {5'd0, jmin_q});
    jdiff  = (ajraw > {1'b0, jest_q}) ? ajraw - {1'b0, jest_q} : {1'b0, jest_q} - ajraw;
    match_ok = !(mag_ok && eff_jestv) || (jdiff <= {5'd0, jtol_q});
    ygate_eff = (ygate_q == 12'd0) ? 12'd1 : ygate_q;
    mmin_eff  = (mmin_q == 16'd0) ? 16'd1 : mmin_q;
    yaw_ok  = yawv_q && (yaw_q <= {4'd0, ygate_eff});
    marg_ok = marg_q >= mmin_q;
    g_ok    = adj && mag_ok && match_ok && yaw_ok && marg_ok;
    need    = (conf_q == 4'd0) ? 4'd1 : conf_q;
    cdl_dec = (bvalid_q && cdl_q != 8'd0) ? cdl_q - 8'd1 : 8'd0;
    tcnt_inc = (tcnt_q < 4'd15) ? {1'b0, tcnt_q} + 5'd1 : 5'd15;
  end

  // EMA and score arithmetic in the score step
  logic [10:0] a_cl;
  logic [31:0] ema_sum;
  logic [31:0] base_sum;
  logic [10:0] base_cl;
  logic [31:0] conf_sum;

  always_comb begin
    a_cl = (alpha_q < 11'd10) ? 11'd10 : (alpha_q > 11'd1024) ? 11'd1024 : alpha_q;
    ema_sum = (32'(11'd1024 - a_cl) * 32'(jest_q)) + (32'(a_cl) * 32'(ajump_q)) + 32'd512;
    base_sum = 32'd512 * 32'(ms_q) + 32'd307 * 32'(ys_q)
             + (gate_q ? 32'd205 * 32'd1024 : 32'd0) + 32'd512;
    base_cl = (base_sum[31:10] > 22'd1024) ? 11'd1024 : base_sum[20:10];
    conf_sum = 32'(1024 - psbq_pkg::ConfFloor) * 32'(base_cl) + 32'd512;
  end

  always_comb begin
    st_d = st_q;
    bvalid_d = bvalid_q; bidx_d = bidx_q; blayer_d = blayer_q;
    tflag_d = tflag_q; tpanel_d = tpanel_q; tcnt_d = tcnt_q; cdl_d = cdl_q;
    pz_d = pz_q; pzv_d = pzv_q; jest_d = jest_q; jestv_d = jestv_q;
    bconf_d = bconf_q;
    ms_d = ms_q; ys_d = ys_q; gate_d = gate_q; done_d = done_q;
    ajump_d = ajump_q; jump_d = jump_q;
    dreq = '0;
    case (st_q)
      ST_IDLE: if (accept) st_d = ST_EVAL;
      ST_EVAL: begin
        done_d = 1'b0;
        case (psbq_pkg::mode_e'(mode_q))
          psbq_pkg::MODE_RESET_Z, psbq_pkg::MODE_RESET_NZ: begin
            bvalid_d = 1'b1; bidx_d = cand_q; blayer_d = pick_layer(label_q, cand_q);
            bconf_d = 11'd512; tflag_d = 1'b0; tpanel_d = '0; tcnt_d = '0;
            cdl_d = '0; jest_d = '0; jestv_d = 1'b0;
            pzv_d = (mode_q == psbq_pkg::MODE_RESET_Z);
            pz_d  = (mode_q == psbq_pkg::MODE_RESET_Z) ? z_q : 16'sd0;
            st_d = ST_FIN;
          end
          psbq_pkg::MODE_BYPASS: begin
            bvalid_d = 1'b1; bidx_d = cand_q; blayer_d = pick_layer(label_q, cand_q);
            bconf_d = (cconf_q > 11'd1024) ? 11'd1024 : cconf_q;
            tflag_d = 1'b0; tpanel_d = '0; tcnt_d = '0;
            pz_d = z_q; pzv_d = 1'b1;
            st_d = ST_FIN;
          end
          default: begin
            // implicit rebind when unbound
            if (!eff_bvalid) begin
              bvalid_d = 1'b1; blayer_d = pick_layer(label_q, cand_q);
              jest_d = '0; jestv_d = 1'b0;
            end
            bidx_d = eff_bidx;
            jump_d = jraw; ajump_d = ajraw; gate_d = g_ok;
            cdl_d = cdl_dec;
            tflag_d = bvalid_q ? tflag_q : 1'b0;
            tpanel_d = bvalid_q ? tpanel_q : 2'd0;
            tcnt_d = bvalid_q ? tcnt_q : 4'd0;
            if (cand_q == eff_bidx) begin
              tflag_d = 1'b0; tpanel_d = '0; tcnt_d = '0;
            end else if (cdl_dec == 8'd0 && g_ok) begin
              if (!tflag_q || !bvalid_q) begin
                if (need <= 4'd1) done_d = 1'b1;
                else begin
                  tflag_d = 1'b1; tpanel_d = cand_q; tcnt_d = 4'd1;
                end
              end else if (cand_q == tpanel_q) begin
                tcnt_d = tcnt_inc[3:0];
                if (tcnt_inc[3:0] >= need) done_d = 1'b1;
              end else begin
                tpanel_d = cand_q; tcnt_d = 4'd1;
              end
            end else begin
              tflag_d = 1'b0; tpanel_d = '0; tcnt_d = '0;
            end
            dreq.start = 1'b1;
            dreq.num = {2'd0, marg_q, 10'd0};
            dreq.den = {1'b0, mmin_eff, 1'b0};
            st_d = ST_DIVM;
          end
        endcase
      end
      ST_DIVM: if (drsp.done) begin
        ms_d = (drsp.quot > 28'd1024) ? 11'd1024 : drsp.quot[10:0];
        dreq.start = 1'b1;
        dreq.num = {6'd0, 12'(ygate_eff - yaw_q[11:0]), 10'd0};
        dreq.den = {6'd0, ygate_eff};
        st_d = ST_DIVY;
      end
      ST_DIVY: if (drsp.done) begin
        ys_d = (yawv_q && yaw_q < {4'd0, ygate_eff}) ? drsp.quot[10:0] : 11'd0;
        st_d = ST_SCORE;
      end
      ST_SCORE: begin
        if (done_q) begin
          bidx_d = cand_q;
          blayer_d = cand_q[0] ? 2'd2 : 2'd1;
          if (pzv_q) begin
            if (jump_q > $signed({5'd0, dz_q})) blayer_d = 2'd2;
            else if (jump_q < -$signed({5'd0, dz_q})) blayer_d = 2'd1;
          end
          if (ajump_q >= {5'd0, jmin_q}) begin
            jestv_d = 1'b1;
            jest_d = jestv_q ? ema_sum[25:10] : ajump_q[15:0];
          end
          tflag_d = 1'b0; tpanel_d = '0; tcnt_d = '0;
          cdl_d = cool_q;
        end
        bconf_d = 11'(psbq_pkg::ConfFloor) + conf_sum[20:10];
        pz_d = z_q; pzv_d = 1'b1;
        st_d = ST_FIN;
      end
      ST_FIN: st_d = ST_OUT;
      ST_OUT: if (!out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // pzv_q must reflect pre-item state during implicit rebind; pzv_d set at EVAL
  // only for modes that finalize there, so observe keeps the old flag until SCORE unless an implicit rebind sets it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      dz_q <= 12'd50; jmin_q <= 12'd30; jtol_q <= 12'd40; ygate_q <= 12'd300;
      mmin_q <= 16'd256; conf_q <= 4'd2; cool_q <= 8'd5; alpha_q <= 11'd307;
      bvalid_q <= 1'b0; bidx_q <= '0; blayer_q <= 2'd1;
      tflag_q <= 1'b0; tpanel_q <= '0; tcnt_q <= '0; cdl_q <= '0;
      pz_q <= '0; pzv_q <= 1'b0; jest_q <= '0; jestv_q <= 1'b0;
      bconf_q <= 11'd512;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (psbq_pkg::reg_e'(cfg_index_i))
          psbq_pkg::REG_LAYER_DZ:  dz_q    <= cfg_data_i[11:0];
          psbq_pkg::REG_JUMP_MIN:  jmin_q  <= cfg_data_i[11:0];
          psbq_pkg::REG_JUMP_TOL:  jtol_q  <= cfg_data_i[11:0];
          psbq_pkg::REG_YAW_GATE:  ygate_q <= cfg_data_i[11:0];
          psbq_pkg::REG_MARGIN:    mmin_q  <= cfg_data_i;
          psbq_pkg::REG_CONFIRM:   conf_q  <= cfg_data_i[3:0];
          psbq_pkg::REG_COOLDOWN:  cool_q  <= cfg_data_i[7:0];
          psbq_pkg::REG_EMA_ALPHA: alpha_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      bvalid_q <= bvalid_d; bidx_q <= bidx_d; blayer_q <= blayer_d;
      tflag_q <= tflag_d; tpanel_q <= tpanel_d; tcnt_q <= tcnt_d; cdl_q <= cdl_d;
      pz_q <= pz_d; jest_q <= jest_d; jestv_q <= jestv_d;
      bconf_q <= bconf_d;
      // implicit rebind marks the height present
      if (st_q == ST_EVAL && mode_q == psbq_pkg::MODE_OBSERVE && !bvalid_q) pzv_q <= 1'b1;
      else pzv_q <= pzv_d;
    end
  end

  logic [10:0] sel;
  assign sel = (cconf_q > bconf_q) ? cconf_q : bconf_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; cand_q <= candidate_panel_i; label_q <= candidate_label_i;
      cconf_q <= candidate_conf_i; z_q <= obs_z_i;
      marg_q <= cost_margin_valid_i ? cost_margin_i : 16'd0;
      yaw_q <= yaw_err_i; yawv_q <= yaw_err_valid_i;
    end
    ms_q <= ms_d; ys_q <= ys_d; gate_q <= gate_d; done_q <= done_d;
    ajump_q <= ajump_d; jump_q <= jump_d;
    if (st_q == ST_FIN) begin
      o_panel_q <= bidx_q; o_label_q <= blayer_q;
      o_sel_q <= (sel > 11'd1024) ? 11'd1024 : sel;
      o_bconf_q <= bconf_q; o_done_q <= done_q; o_trans_q <= tflag_q;
    end
  end

  assign bound_panel_o   = o_panel_q;
  assign bound_label_o   = o_label_q;
  assign selected_conf_o = o_sel_q;
  assign binding_conf_o  = o_bconf_q;
  assign switch_done_o   = o_done_q;
  assign in_transition_o = o_trans_q;
endmodule

[rtl/core/psbq_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on psbq_pkg.
`timescale 1ns / 1ps
module psbq_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psbq_pkg::div_req_t req_i,
  output psbq_pkg::div_rsp_t rsp_o
);
  logic [27:0] quot_q, quot_d;
  logic [18:0] rem_q, rem_d;
  logic [17:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [18:0] trial;

  always_comb begin
    quot_d = quot_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial  = {rem_q[17:0], quot_q[27]};
    if (req_i.start) begin
      quot_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = 5'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[26:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[26:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd27) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule
